@@ rtl/midi_note_sine_tone_generator_macros.svh @@
// -----------------------------------------------------------------------------
// MIDI note sine tone generator assertion macros
// Concurrent assertion shorthands; they compile to nothing in synthesis.
// -----------------------------------------------------------------------------
`ifndef MIDI_NOTE_SINE_TONE_GENERATOR_MACROS_SVH
`define MIDI_NOTE_SINE_TONE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define MNTG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// The condition must never be true outside reset.
`define MNTG_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define MNTG_ASSERT(lbl, clk, rst_n, prop)
`define MNTG_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/mntg_pkg.sv @@
// -----------------------------------------------------------------------------
// MIDI note sine tone generator package
// Widths, codes and the constant phase step and sine tables.
// -----------------------------------------------------------------------------
package mntg_pkg;

	localparam int PHASE_BITS     = 32;
	localparam int SINE_ADDR_BITS = 10;
	localparam int SAMPLE_RATE_HZ = 8000;

	localparam int SINE_SIZE  = 1 << SINE_ADDR_BITS;
	localparam int QUARTER    = SINE_SIZE / 4;
	localparam int NOTE_COUNT = 128;
	localparam int STEP_SHIFT = PHASE_BITS - 31;

	localparam logic [63:0] BASE_FREQ_Q32 = 64'd35114793619;
	localparam logic [63:0] SEMITONE_Q32  = 64'd4550359342;
	localparam logic [63:0] TWO_PI_Q30    = 64'd6746518852;
	localparam logic [63:0] ONE_Q30       = 64'd1 << 30;

	localparam logic [15:0] TONE_LENGTH_RESET = 16'd8000;

	// Register index decoded from the APB address.
	localparam logic REG_TONE_LENGTH = 1'b0;

	localparam logic ACTION_BYTE = 1'b0;
	localparam logic ACTION_TICK = 1'b1;

	localparam logic KIND_MESSAGE = 1'b0;
	localparam logic KIND_SAMPLE  = 1'b1;

	// Status high nibbles.
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_PRESSURE = 4'hD;
	localparam logic [3:0] NIB_SYSTEM   = 4'hF;

	typedef enum logic [1:0] {
		PS_WAIT_STATUS = 2'd0,
		PS_WANT_FIRST  = 2'd1,
		PS_WANT_SECOND = 2'd2
	} parse_t;

	typedef logic [PHASE_BITS-1:0] phase_t;
	typedef phase_t step_rom_t [NOTE_COUNT];
	typedef logic [7:0] sine_rom_t [SINE_SIZE];

	// Multiplies a Q4.32 frequency by the semitone ratio, rounding half up.
	function automatic logic [63:0] mul_ratio(input logic [63:0] f);
		logic [63:0] hi;
		logic [63:0] lo;
		hi = f * (SEMITONE_Q32 >> 16);
		lo = f * (SEMITONE_Q32 & 64'hFFFF) + (64'd1 << 31);
		return (hi + (lo >> 16)) >> 16;
	endfunction

	function automatic step_rom_t build_step_rom();
		logic [63:0] semi [12];
		logic [63:0] f;
		logic [63:0] q;
		logic [63:0] r;
		step_rom_t rom;
		semi[0] = BASE_FREQ_Q32;
		for (int i = 1; i < 12; i++) begin
			semi[i] = mul_ratio(semi[i-1]);
		end
		for (int n = 0; n < NOTE_COUNT; n++) begin
			f = semi[n % 12] << (n / 12);
			q = f / 64'(SAMPLE_RATE_HZ);
			r = f % 64'(SAMPLE_RATE_HZ);
			if (STEP_SHIFT >= 0) begin
				for (int i = 0; i < STEP_SHIFT; i++) begin
					r = r << 1;
					q = q << 1;
					if (r >= 64'(SAMPLE_RATE_HZ)) begin
						q = q | 64'd1;
						r = r - 64'(SAMPLE_RATE_HZ);
					end
				end
			end else begin
				q = q >> (31 - PHASE_BITS);
			end
			q = (q + 64'd1) >> 1;
			rom[n] = q[PHASE_BITS-1:0];
		end
		return rom;
	endfunction

	// sin(j * 2pi / SINE_SIZE) in Q2.30 for j in 0..QUARTER, by Taylor sums.
	function automatic longint quarter_sine(input int j);
		logic use_cos;
		int a;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] p;
		longint sum;
		use_cos = j > (QUARTER / 2);
		a = use_cos ? QUARTER - j : j;
		x = (64'(a) * TWO_PI_Q30) >> SINE_ADDR_BITS;
		x2 = (x * x) >> 30;
		term = use_cos ? ONE_Q30 : x;
		sum = longint'(term);
		for (int k = 1; k <= 4; k++) begin
			p = (term * x2) >> 30;
			if (use_cos) begin
				unique case (k)
					1: term = p / 64'd2;
					2: term = p / 64'd12;
					3: term = p / 64'd30;
					default: term = p / 64'd56;
				endcase
			end else begin
				unique case (k)
					1: term = p / 64'd6;
					2: term = p / 64'd20;
					3: term = p / 64'd42;
					default: term = p / 64'd72;
				endcase
			end
			if ((k % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ONE_Q30)) begin
			sum = longint'(ONE_Q30);
		end
		return sum;
	endfunction

	function automatic sine_rom_t build_sine_rom();
		int quad;
		int j;
		longint s;
		logic [63:0] v;
		sine_rom_t rom;
		for (int i = 0; i < SINE_SIZE; i++) begin
			quad = i >> (SINE_ADDR_BITS - 2);
			j = i & (QUARTER - 1);
			s = ((quad % 2) == 1) ? quarter_sine(QUARTER - j) : quarter_sine(j);
			if (quad >= 2) begin
				s = -s;
			end
			v = ((ONE_Q30 + 64'(s)) * 64'd255) >> 31;
			rom[i] = v[7:0];
		end
		return rom;
	endfunction

	localparam step_rom_t STEP_ROM = build_step_rom();
	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ rtl/midi_note_sine_tone_generator.sv @@
// -----------------------------------------------------------------------------
// MIDI note sine tone generator
// Parses MIDI messages, plays a fixed-length sine tone for each note-on.
// -----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall is low: a MIDI
// byte or a sample tick. Every completed MIDI message is passed out, and
// every tick while a tone plays yields one 8-bit sample. A result passes
// through the stage-one register and then the output register; the sine
// table is a synchronous ROM with a registered read, and the output register
// behind it lets the input keep flowing while a result waits. A note-on with
// nonzero velocity restarts the tone at phase zero for tone_length samples.
`include "midi_note_sine_tone_generator_macros.svh"

module midi_note_sine_tone_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  midi_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  status_byte,
	output logic [7:0]  first_data,
	output logic [7:0]  second_data,
	output logic [7:0]  sample,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mntg_pkg::*;

	parse_t      parse_q, parse_d;
	logic [7:0]  held_status_q, held_status_d;
	logic [7:0]  held_first_q, held_first_d;
	logic        tone_active_q, tone_active_d;
	logic [15:0] samples_left_q, samples_left_d;
	phase_t      phase_acc_q, phase_acc_d;
	phase_t      phase_step_q, phase_step_d;
	logic [15:0] tone_length_q;

	logic        acc;
	logic        out_free;
	logic        note_on;
	logic [3:0]  nib;
	logic        res_valid;
	logic        res_kind;
	logic [7:0]  res_status;
	logic [7:0]  res_first;
	logic [7:0]  res_second;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  status_s1;
	logic [7:0]  first_s1;
	logic [7:0]  second_s1;
	logic [7:0]  sample_s1;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  status_q;
	logic [7:0]  first_q;
	logic [7:0]  second_q;
	logic [7:0]  sample_q;

	// Stage one moves on whenever the output register is empty or being taken.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign acc      = in_valid && !in_stall;
	assign nib      = held_status_q[7:4];

	always_comb begin
		parse_d        = parse_q;
		held_status_d  = held_status_q;
		held_first_d   = held_first_q;
		tone_active_d  = tone_active_q;
		samples_left_d = samples_left_q;
		phase_acc_d    = phase_acc_q;
		phase_step_d   = phase_step_q;
		note_on        = 1'b0;
		res_valid      = 1'b0;
		res_kind       = KIND_MESSAGE;
		res_status     = 8'd0;
		res_first      = 8'd0;
		res_second     = 8'd0;
		if (acc) begin
			if (action == ACTION_TICK) begin
				if (tone_active_q) begin
					res_valid      = 1'b1;
					res_kind       = KIND_SAMPLE;
					phase_acc_d    = phase_acc_q + phase_step_q;
					samples_left_d = samples_left_q - 16'd1;
					if (samples_left_d == 16'd0) begin
						tone_active_d = 1'b0;
					end
				end
			end else begin
				unique case (parse_q)
					PS_WANT_FIRST: begin
						if (nib == NIB_PROGRAM || nib == NIB_PRESSURE || nib == NIB_SYSTEM) begin
							parse_d    = PS_WAIT_STATUS;
							res_valid  = 1'b1;
							res_status = held_status_q;
							res_first  = midi_byte;
						end else begin
							held_first_d = midi_byte;
							parse_d      = PS_WANT_SECOND;
						end
					end
					PS_WANT_SECOND: begin
						parse_d    = PS_WAIT_STATUS;
						res_valid  = 1'b1;
						res_status = held_status_q;
						res_first  = held_first_q;
						res_second = midi_byte;
						if (nib == NIB_NOTE_ON && midi_byte != 8'd0) begin
							note_on        = 1'b1;
							phase_step_d   = STEP_ROM[held_first_q[6:0]];
							phase_acc_d    = '0;
							samples_left_d = tone_length_q;
							tone_active_d  = tone_length_q != 16'd0;
						end
					end
					default: begin
						// Stray data bytes are dropped until a status byte shows up.
						parse_d = PS_WAIT_STATUS;
						if (midi_byte[7]) begin
							held_status_d = midi_byte;
							parse_d       = PS_WANT_FIRST;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q        <= PS_WAIT_STATUS;
			held_status_q  <= 8'd0;
			held_first_q   <= 8'd0;
			tone_active_q  <= 1'b0;
			samples_left_q <= 16'd0;
			phase_acc_q    <= '0;
			phase_step_q   <= '0;
		end else begin
			parse_q        <= parse_d;
			held_status_q  <= held_status_d;
			held_first_q   <= held_first_d;
			tone_active_q  <= tone_active_d;
			samples_left_q <= samples_left_d;
			phase_acc_q    <= phase_acc_d;
			phase_step_q   <= phase_step_d;
		end
	end

	// Sine ROM with a registered read at the current phase.
	always_ff @(posedge clk) begin
		if (acc && action == ACTION_TICK) begin
			sample_s1 <= SINE_ROM[phase_acc_q[PHASE_BITS-1 -: SINE_ADDR_BITS]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= res_valid;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1   <= res_kind;
			status_s1 <= res_status;
			first_s1  <= res_first;
			second_s1 <= res_second;
		end
		if (out_free && valid_s1) begin
			kind_q   <= kind_s1;
			status_q <= status_s1;
			first_q  <= first_s1;
			second_q <= second_s1;
			sample_q <= (kind_s1 == KIND_SAMPLE) ? sample_s1 : 8'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign status_byte = status_q;
	assign first_data  = first_q;
	assign second_data = second_q;
	assign sample      = sample_q;

	// Configuration port; addresses outside the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_length_q <= TONE_LENGTH_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TONE_LENGTH) begin
			tone_length_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_TONE_LENGTH) ? {16'd0, tone_length_q} : 32'd0;
	assign pready = 1'b1;

	`MNTG_ASSERT(a_active_has_samples, clk, arst_n, !tone_active_q || (samples_left_q != 16'd0))
	`MNTG_ASSERT(a_tick_gives_sample, clk, arst_n, (acc && action == ACTION_TICK && tone_active_q) |=> (valid_s1 && kind_s1 == KIND_SAMPLE))
	`MNTG_ASSERT(a_note_on_restarts, clk, arst_n, note_on |=> (phase_acc_q == '0))
	`MNTG_ASSERT_NEVER(a_short_msg_no_second, clk, arst_n, parse_q == PS_WANT_SECOND && (nib == NIB_PROGRAM || nib == NIB_PRESSURE || nib == NIB_SYSTEM))

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// MIDI note sine tone generator testbench
// Feeds MIDI bytes and sample ticks through the valid/stall input channel and
// programs the tone length over APB. A local copy of the parser and oscillator
// state, with its own step and sine tables, works out every message and
// sample, and each output transfer is compared field by field in order.
// -----------------------------------------------------------------------------
module tb_top;
	import mntg_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [7:0] status_byte;
		logic [7:0] first_data;
		logic [7:0] second_data;
		logic [7:0] sample;
	} synth_out_t;

	localparam logic [2:0] TONE_LENGTH_ADDR = {REG_TONE_LENGTH, 2'b00};
	localparam logic [2:0] UNUSED_REG_ADDR  = 3'b100;
	localparam int         SETTLE_CYCLES    = 8;
	localparam int         PHASE_ITEMS      = 265;
	localparam int         SEND_IDLE [4]    = '{0, 75, 0, 22};
	localparam int         RECV_STALL [4]   = '{0, 0, 75, 22};
	localparam int         PHASE_LENGTH [4] = '{24, 65535, 1, 300};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [7:0]  midi_byte;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [7:0]  status_byte;
	logic [7:0]  first_data;
	logic [7:0]  second_data;
	logic [7:0]  sample;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Local copy of the block state and its tables.
	phase_t      note_step_table [NOTE_COUNT];
	logic [7:0]  sine_table [SINE_SIZE];
	logic [15:0] tone_len;
	parse_t      parse_state;
	logic [7:0]  held_status;
	logic [7:0]  held_first;
	logic        tone_on;
	logic [15:0] samples_left;
	phase_t      tone_phase;
	phase_t      tone_step;

	synth_out_t  queued_outputs [$];
	int          fail_count;
	int          sent_items;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_left;

	midi_note_sine_tone_generator dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	function automatic void build_tables();
		logic [63:0] semi [12];
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] f;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] v;
		longint      quarter_sin [QUARTER + 1];
		longint      acc;
		longint      s;
		logic        use_cos;
		int          a;
		int          d;
		int          quad;
		int          j;
		semi[0] = BASE_FREQ_Q32;
		for (int i = 1; i < 12; i++) begin
			hi = semi[i-1] * (SEMITONE_Q32 >> 16);
			lo = semi[i-1] * {48'd0, SEMITONE_Q32[15:0]} + (64'd1 << 31);
			semi[i] = (hi + (lo >> 16)) >> 16;
		end
		// One extra bit of quotient below the phase LSB is kept for rounding.
		for (int n = 0; n < NOTE_COUNT; n++) begin
			f = semi[n % 12] << (n / 12);
			q = f / 64'(SAMPLE_RATE_HZ);
			rem = f % 64'(SAMPLE_RATE_HZ);
			if (PHASE_BITS - 31 >= 0) begin
				for (int i = 0; i < PHASE_BITS - 31; i++) begin
					rem = rem << 1;
					q = {q[62:0], 1'b0};
					if (rem >= 64'(SAMPLE_RATE_HZ)) begin
						q[0] = 1'b1;
						rem = rem - 64'(SAMPLE_RATE_HZ);
					end
				end
			end else begin
				q = q >> (31 - PHASE_BITS);
			end
			q = (q + 64'd1) >> 1;
			note_step_table[n] = q[PHASE_BITS-1:0];
		end
		// First quadrant: sine series near zero, cosine series of the complement above.
		for (int jj = 0; jj <= QUARTER; jj++) begin
			use_cos = jj > (QUARTER / 2);
			a = use_cos ? QUARTER - jj : jj;
			x = (64'(a) * TWO_PI_Q30) >> SINE_ADDR_BITS;
			x2 = (x * x) >> 30;
			term = use_cos ? ONE_Q30 : x;
			acc = longint'(term);
			d = use_cos ? 1 : 2;
			for (int k = 1; k <= 4; k++) begin
				term = ((term * x2) >> 30) / 64'(d * (d + 1));
				d = d + 2;
				if (k % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > longint'(ONE_Q30)) begin
				acc = longint'(ONE_Q30);
			end
			quarter_sin[jj] = acc;
		end
		for (int i = 0; i < SINE_SIZE; i++) begin
			quad = i / QUARTER;
			j = i % QUARTER;
			s = (quad % 2 == 1) ? quarter_sin[QUARTER - j] : quarter_sin[j];
			if (quad >= 2) begin
				s = -s;
			end
			v = (ONE_Q30 + 64'(s)) * 64'd255;
			v = v >> 31;
			sine_table[i] = v[7:0];
		end
	endfunction

	// Advances the local state by one item; returns 1 when a result leaves.
	function automatic bit parse_and_play(input logic act, input logic [7:0] b,
			output synth_out_t r);
		logic [3:0] nib;
		r = '0;
		if (act == ACTION_TICK) begin
			if (!tone_on) begin
				return 1'b0;
			end
			r.kind = KIND_SAMPLE;
			r.sample = sine_table[tone_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]];
			tone_phase = tone_phase + tone_step;
			samples_left = samples_left - 16'd1;
			if (samples_left == 16'd0) begin
				tone_on = 1'b0;
			end
			return 1'b1;
		end
		nib = held_status[7:4];
		case (parse_state)
			PS_WANT_FIRST: begin
				if (nib == NIB_PROGRAM || nib == NIB_PRESSURE || nib == NIB_SYSTEM) begin
					parse_state = PS_WAIT_STATUS;
					r.kind = KIND_MESSAGE;
					r.status_byte = held_status;
					r.first_data = b;
					return 1'b1;
				end
				held_first = b;
				parse_state = PS_WANT_SECOND;
				return 1'b0;
			end
			PS_WANT_SECOND: begin
				parse_state = PS_WAIT_STATUS;
				r.kind = KIND_MESSAGE;
				r.status_byte = held_status;
				r.first_data = held_first;
				r.second_data = b;
				if (nib == NIB_NOTE_ON && b != 8'd0) begin
					tone_step = note_step_table[held_first[6:0]];
					tone_phase = '0;
					samples_left = tone_len;
					tone_on = tone_len != 16'd0;
				end
				return 1'b1;
			end
			default: begin
				parse_state = PS_WAIT_STATUS;
				if (b[7]) begin
					held_status = b;
					parse_state = PS_WANT_FIRST;
				end
				return 1'b0;
			end
		endcase
	endfunction

	task automatic send_item(input logic act, input logic [7:0] b);
		synth_out_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		midi_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sent_items++;
		if (parse_and_play(act, b, r)) begin
			queued_outputs.push_back(r);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (queued_outputs.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (addr[2] == REG_TONE_LENGTH) begin
			tone_len = data[15:0];
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_tone_length();
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= TONE_LENGTH_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		got = prdata;
		if (got[15:0] !== tone_len) begin
			fail_count++;
			$display("%0t: tone_length readback mismatch, expected %0d, actual %0d",
				$time, tone_len, got[15:0]);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_tone_length(input int len);
		settle();
		write_reg(TONE_LENGTH_ADDR, 32'(len));
		check_tone_length();
	endtask

	function automatic logic [7:0] rand_data();
		return ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(127));
	endfunction

	// One message or tick run; mostly well-formed, some noise and cut messages.
	task automatic random_burst();
		int         pick;
		logic [7:0] st;
		pick = $urandom_range(99);
		if (pick < 45) begin
			send_item(ACTION_BYTE, {NIB_NOTE_ON, 4'($urandom_range(15))});
			send_item(ACTION_BYTE, rand_data());
			send_item(ACTION_BYTE, ($urandom_range(4) == 0) ? 8'h00 : rand_data());
			repeat ($urandom_range(24)) send_item(ACTION_TICK, 8'($urandom));
		end else if (pick < 70) begin
			st = 8'($urandom_range(8'h80, 8'hFF));
			send_item(ACTION_BYTE, st);
			send_item(ACTION_BYTE, rand_data());
			if (!(st[7:4] == NIB_PROGRAM || st[7:4] == NIB_PRESSURE || st[7:4] == NIB_SYSTEM)) begin
				send_item(ACTION_BYTE, rand_data());
			end
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 10)) send_item(ACTION_TICK, 8'($urandom));
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 3)) send_item(ACTION_BYTE, 8'($urandom));
		end else begin
			send_item(ACTION_BYTE, 8'($urandom_range(8'h80, 8'hFF)));
			send_item(ACTION_BYTE, 8'($urandom_range(8'h80, 8'hFF)));
			repeat ($urandom_range(2)) send_item(ACTION_BYTE, 8'($urandom));
		end
	endtask

	task automatic test_message_parsing();
		send_item(ACTION_TICK, 8'h00);
		send_item(ACTION_BYTE, 8'h7F);
		send_item(ACTION_BYTE, 8'hC5);
		send_item(ACTION_BYTE, 8'h00);
		// A status byte inside a message counts as data.
		send_item(ACTION_BYTE, 8'hFE);
		send_item(ACTION_BYTE, 8'hFF);
		send_item(ACTION_BYTE, 8'hE3);
		send_item(ACTION_BYTE, 8'h80);
		send_item(ACTION_BYTE, 8'h7F);
	endtask

	task automatic test_note_tones();
		set_tone_length(3);
		send_item(ACTION_BYTE, 8'h90);
		send_item(ACTION_BYTE, 8'h00);
		send_item(ACTION_BYTE, 8'h7F);
		send_item(ACTION_TICK, 8'hFF);
		// Zero velocity must leave the running tone alone.
		send_item(ACTION_BYTE, 8'h9F);
		send_item(ACTION_BYTE, 8'h40);
		send_item(ACTION_BYTE, 8'h00);
		send_item(ACTION_TICK, 8'h00);
		send_item(ACTION_BYTE, 8'h90);
		send_item(ACTION_BYTE, 8'hFF);
		send_item(ACTION_BYTE, 8'h01);
		send_item(ACTION_TICK, 8'h00);
		settle();
		write_reg(UNUSED_REG_ADDR, 32'd5);
		check_tone_length();
		set_tone_length(0);
		send_item(ACTION_BYTE, 8'h95);
		send_item(ACTION_BYTE, 8'h3C);
		send_item(ACTION_BYTE, 8'h40);
		send_item(ACTION_TICK, 8'h00);
	endtask

	task automatic test_backpressure();
		set_tone_length(65535);
		send_item(ACTION_BYTE, 8'h92);
		send_item(ACTION_BYTE, 8'h45);
		send_item(ACTION_BYTE, 8'h60);
		hold_left = 200;
		repeat (40) send_item(ACTION_TICK, 8'($urandom));
		repeat (6) begin
			send_item(ACTION_BYTE, 8'hC1);
			send_item(ACTION_BYTE, rand_data());
		end
		settle();
	endtask

	task automatic test_random_traffic();
		int goal;
		for (int p = 0; p < 4; p++) begin
			set_tone_length(PHASE_LENGTH[p]);
			send_idle_pct = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			goal = sent_items + PHASE_ITEMS;
			while (sent_items < goal) begin
				random_burst();
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		synth_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (queued_outputs.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected output transfer, expected none, actual kind %0d",
					$time, kind);
			end else begin
				want = queued_outputs.pop_front();
				check_field("kind", 8'(want.kind), 8'(kind));
				check_field("status_byte", want.status_byte, status_byte);
				check_field("first_data", want.first_data, first_data);
				check_field("second_data", want.second_data, second_data);
				check_field("sample", want.sample, sample);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACTION_BYTE;
		midi_byte = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		sent_items = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		build_tables();
		tone_len = TONE_LENGTH_RESET;
		parse_state = PS_WAIT_STATUS;
		held_status = '0;
		held_first = '0;
		tone_on = 1'b0;
		samples_left = '0;
		tone_phase = '0;
		tone_step = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_message_parsing();
		test_note_tones();
		test_backpressure();
		test_random_traffic();
		settle();

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
